// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the frame block builder RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/pfbb_pkg.sv -----
// Types and codes for the padded frame block builder.
// No dependencies; imported by every module of the block.
package pfbb_pkg;

    localparam logic       MODE_HEADER = 1'b0;
    localparam logic       MODE_DEVICE = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_COUNT_OVER = 2'd1;
    localparam logic [1:0] STATUS_NO_DEVICE  = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [47:0] gateway_id;
        logic [7:0]  device_count;
        logic [63:0] payload;
    } t_in_item;

    typedef struct packed {
        logic [63:0] block_low;
        logic [63:0] block_high;
        logic        is_header;
        logic        last;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic       block_en;
        logic       is_header;
        logic       last;
        logic [1:0] status;
    } t_frame_ctl;

endpackage

// ----- rtl/pfbb_pad.sv -----
// Combinational block derivation: header and device pad bytes.
// Depends on pfbb_pkg.
module pfbb_pad (
    input  pfbb_pkg::t_in_item i_item,
    output logic [63:0]        o_block_low,
    output logic [63:0]        o_block_high
);
    import pfbb_pkg::*;

    logic [7:0] g [6];
    logic [7:0] dc;
    logic [7:0] hs, hx;
    logic [7:0] hb [16];
    logic [7:0] p [8];
    logic [7:0] ds, dx;
    logic [7:0] db [8];
    logic [63:0] hdr_lo, hdr_hi, dev_hi;

    // Header block: id, count, nine pad bytes.
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            g[i] = i_item.gateway_id[8*i +: 8];
        end
        dc = i_item.device_count;
        hs = g[0] + g[1] + g[2] + g[3] + g[4] + g[5] + dc;
        hx = g[0] ^ g[1] ^ g[2] ^ g[3] ^ g[4] ^ g[5] ^ dc;
        for (int i = 0; i < 6; i++) begin
            hb[i] = g[i];
        end
        hb[6]  = dc;
        hb[7]  = hs;
        hb[8]  = hx;
        hb[9]  = {g[0][6:0], g[0][7]} ^ g[5];
        hb[10] = g[1] + g[4] + dc;
        hb[11] = g[2] ^ 8'(g[0] + g[5]);
        hb[12] = g[3] + {g[2][6:0], 1'b0};
        hb[13] = 8'(g[0] * g[2]) + (g[3] ^ dc);
        hb[14] = 8'(hx + hs) ^ g[4];
        hb[15] = 8'(hs - dc) ^ g[1];
        for (int i = 0; i < 8; i++) begin
            hdr_lo[8*i +: 8] = hb[i];
            hdr_hi[8*i +: 8] = hb[i+8];
        end
    end

    // Device block: payload, eight pad bytes.
    always_comb begin
        ds = '0;
        dx = '0;
        for (int i = 0; i < 8; i++) begin
            p[i] = i_item.payload[8*i +: 8];
            ds   = ds + p[i];
            dx   = dx ^ p[i];
        end
        db[0] = ds;
        db[1] = dx;
        db[2] = 8'(p[0] + p[3]) ^ p[6];
        db[3] = p[1] + p[4] + ds;
        db[4] = p[2] ^ p[5] ^ dx;
        db[5] = {p[7][6:0], 1'b0} + p[0];
        db[6] = 8'(p[1] * p[2]) + (p[3] | p[4]);
        db[7] = 8'(dx + ds) ^ p[7];
        for (int i = 0; i < 8; i++) begin
            dev_hi[8*i +: 8] = db[i];
        end
    end

    assign o_block_low  = (i_item.mode == MODE_HEADER) ? hdr_lo : i_item.payload;
    assign o_block_high = (i_item.mode == MODE_HEADER) ? hdr_hi : dev_hi;

endmodule

// ----- rtl/pfbb_frame_ctl.sv -----
// Frame tracking: device blocks still expected, last marker and status.
// Depends on pfbb_pkg and assert_macros.svh.
module pfbb_frame_ctl #(
    parameter int MAX_DEVICES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic                 i_mode,
    input  logic [7:0]           i_device_count,
    output pfbb_pkg::t_frame_ctl o_ctl
);
    import pfbb_pkg::*;
    `include "assert_macros.svh"

    localparam logic [7:0] MaxDev = 8'(MAX_DEVICES);

    logic [7:0] r_remaining, n_remaining;
    logic [7:0] dec_remaining;

    assign dec_remaining = r_remaining - 8'd1;

    always_comb begin
        o_ctl       = '0;
        n_remaining = r_remaining;
        if (i_mode == MODE_HEADER) begin
            if (i_device_count > MaxDev) begin
                o_ctl.status = STATUS_COUNT_OVER;
                n_remaining  = '0;
            end else begin
                o_ctl.block_en  = 1'b1;
                o_ctl.is_header = 1'b1;
                o_ctl.last      = (i_device_count == 8'd0);
                n_remaining     = i_device_count;
            end
        end else begin
            if (r_remaining == 8'd0) begin
                o_ctl.status = STATUS_NO_DEVICE;
            end else begin
                o_ctl.block_en = 1'b1;
                o_ctl.last     = (dec_remaining == 8'd0);
                n_remaining    = dec_remaining;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
        end else if (i_advance) begin
            r_remaining <= n_remaining;
        end
    end

    `ASSERT_CLK(a_over_clears, i_clk, i_rst_n,
        (i_advance && o_ctl.status == STATUS_COUNT_OVER) |=> (r_remaining == 8'd0),
        "count over maximum did not abort the frame")
    `ASSERT_CLK(a_device_decrements, i_clk, i_rst_n,
        (i_advance && i_mode == MODE_DEVICE && o_ctl.status == STATUS_OK)
            |=> (r_remaining == 8'($past(r_remaining) - 8'd1)),
        "device block did not consume one expected block")
    `ASSERT_CLK(a_remaining_bounded, i_clk, i_rst_n,
        (r_remaining <= MaxDev),
        "expected device count above the maximum")

endmodule

// ----- rtl/padded_frame_block_builder.sv -----
// Padded frame block builder: one 16-byte block word out for every item word in.
// Throughput: 1 word per cycle while the sink does not stall the output; set by the
// single pass of pad logic between the input register and the result register, with
// the frame counter updated alongside.
// Reset (synchronous, active low) empties both registers and clears the count of
// device blocks still expected.
module padded_frame_block_builder #(
    parameter int MAX_DEVICES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pfbb_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output pfbb_pkg::t_out_item  o_out
);
    import pfbb_pkg::*;
    `include "assert_macros.svh"

    // Input register: holds the accepted item word until the result register frees.
    logic       r_in_valid;
    t_in_item   r_in;

    // Result register: holds the finished block word until the sink takes it.
    logic       r_out_valid;
    t_out_item  r_out;

    logic       out_free;
    logic       advance;
    logic       in_free;

    logic [63:0] pad_low, pad_high;
    t_frame_ctl  ctl;
    t_out_item   n_out;

    // Advance the input word whenever the result register is empty or being drained;
    // take a new word whenever the input register is empty or advancing.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign in_free    = !r_in_valid || advance;
    assign o_in_stall = !in_free;

    pfbb_pad u_pad (
        .i_item       (r_in),
        .o_block_low  (pad_low),
        .o_block_high (pad_high)
    );

    // The frame counter moves only when the word it judged moves to the result register.
    pfbb_frame_ctl #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_frame_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (advance),
        .i_mode         (r_in.mode),
        .i_device_count (r_in.device_count),
        .o_ctl          (ctl)
    );

    // Drop the block bytes on an error word: every field but status reads zero.
    always_comb begin
        n_out.block_low  = ctl.block_en ? pad_low  : '0;
        n_out.block_high = ctl.block_en ? pad_high : '0;
        n_out.is_header  = ctl.is_header;
        n_out.last       = ctl.last;
        n_out.status     = ctl.status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_CLK(a_error_word_empty, i_clk, i_rst_n,
        (r_out_valid && r_out.status != STATUS_OK)
            |-> (r_out.block_low == '0 && r_out.block_high == '0
                 && !r_out.is_header && !r_out.last),
        "error word carries block fields")
    `ASSERT_CLK(a_held_word_kept, i_clk, i_rst_n,
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in)),
        "input word lost while the result register was full")
    `ASSERT_CLK(a_stalled_out_kept, i_clk, i_rst_n,
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)),
        "result word changed while stalled")

endmodule

// ----- bench/tb_padded_frame_block_builder.sv -----
// Self-checking bench for padded_frame_block_builder: header and device words go in,
// 16-byte blocks come out and are compared against an in-bench model of the pad logic.
// Depends on pfbb_pkg and the padded_frame_block_builder RTL only.
module tb_padded_frame_block_builder;
    import pfbb_pkg::*;

    localparam int MAX_DEVICES    = 32;
    // The block holds a couple of words, so a quiet spell far beyond the hold-off
    // below and the longest random stall run means the pipeline has hung.
    localparam int QUIET_LIMIT    = 3000;
    localparam int HOLDOFF_CYCLES = 400;
    // Extra wait after the last expected block, to catch stray output words.
    localparam int DRAIN_CYCLES   = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;

    // Predicted blocks, oldest first, and the frame counter the model keeps.
    t_out_item  expected_blocks[$];
    t_out_item  next_block;
    logic [7:0] frame_left = 8'd0;

    int words_sent    = 0;
    int fail_count    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Hold-off requests: the stimulus bumps holdoff_req, the output side notices
    // the change and counts the stretch out itself.
    int holdoff_req   = 0;
    int holdoff_seen  = 0;
    int holdoff_left  = 0;

    padded_frame_block_builder #(
        .MAX_DEVICES (MAX_DEVICES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Work out the block for one accepted word and advance the frame counter.
    function automatic t_out_item predict_block(input t_in_item w);
        t_out_item  r;
        logic [7:0] g [6];
        logic [7:0] p [8];
        logic [7:0] pad [8];
        logic [7:0] dc;
        logic [7:0] s;
        logic [7:0] x;
        int         i;
        r = '0;
        if (w.mode == MODE_HEADER) begin
            if (w.device_count > MAX_DEVICES) begin
                // Abort the frame: blank block, error status.
                r.status   = STATUS_COUNT_OVER;
                frame_left = 8'd0;
            end else begin
                dc = w.device_count;
                s  = dc;
                x  = dc;
                for (i = 0; i < 6; i++) begin
                    g[i] = w.gateway_id[8*i +: 8];
                    s    = s + g[i];
                    x    = x ^ g[i];
                end
                pad[0] = x;
                pad[1] = {g[0][6:0], g[0][7]} ^ g[5];
                pad[2] = g[1] + g[4] + dc;
                pad[3] = g[2] ^ 8'(g[0] + g[5]);
                pad[4] = g[3] + 8'(g[2] << 1);
                pad[5] = 8'(g[0] * g[2]) + (g[3] ^ dc);
                pad[6] = 8'(x + s) ^ g[4];
                pad[7] = 8'(s - dc) ^ g[1];
                r.block_low = {s, dc, w.gateway_id};
                for (i = 0; i < 8; i++)
                    r.block_high[8*i +: 8] = pad[i];
                r.is_header = 1'b1;
                r.last      = (dc == 8'd0);
                // A header mid-frame simply reloads the count.
                frame_left  = dc;
            end
        end else if (frame_left == 8'd0) begin
            // Stray device word: error, counter left alone.
            r.status = STATUS_NO_DEVICE;
        end else begin
            s = 8'd0;
            x = 8'd0;
            for (i = 0; i < 8; i++) begin
                p[i] = w.payload[8*i +: 8];
                s    = s + p[i];
                x    = x ^ p[i];
            end
            pad[0] = s;
            pad[1] = x;
            pad[2] = 8'(p[0] + p[3]) ^ p[6];
            pad[3] = p[1] + p[4] + s;
            pad[4] = p[2] ^ p[5] ^ x;
            pad[5] = 8'(p[7] << 1) + p[0];
            pad[6] = 8'(p[1] * p[2]) + (p[3] | p[4]);
            pad[7] = 8'(x + s) ^ p[7];
            r.block_low = w.payload;
            for (i = 0; i < 8; i++)
                r.block_high[8*i +: 8] = pad[i];
            frame_left = frame_left - 8'd1;
            r.last     = (frame_left == 8'd0);
        end
        return r;
    endfunction

    // Header word; the payload is unused, so fill it with noise.
    function automatic t_in_item header_word(input logic [47:0] id, input logic [7:0] count);
        t_in_item w;
        w.mode         = MODE_HEADER;
        w.gateway_id   = id;
        w.device_count = count;
        w.payload      = rand64();
        return w;
    endfunction

    // Device word; id and count are unused, so fill them with noise.
    function automatic t_in_item device_word(input logic [63:0] pl);
        t_in_item    w;
        logic [63:0] r;
        r              = rand64();
        w.mode         = MODE_DEVICE;
        w.gateway_id   = r[47:0];
        w.device_count = r[55:48];
        w.payload      = pl;
        return w;
    endfunction

    // Offer one word, hold it until taken, then record its predicted block.
    // Leave valid high on return so back-to-back words need no toggle.
    task automatic send_word(input t_in_item w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        expected_blocks.push_back(predict_block(w));
        words_sent++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    // Output side: check each word taken, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                $error("output word with no block expected");
                fail_count++;
            end else begin
                next_block = expected_blocks.pop_front();
                check_field("block_low",  next_block.block_low,  o_out.block_low);
                check_field("block_high", next_block.block_high, o_out.block_high);
                check_field("is_header",  64'(next_block.is_header), 64'(o_out.is_header));
                check_field("last",       64'(next_block.last),      64'(o_out.last));
                check_field("status",     64'(next_block.status),    64'(o_out.status));
            end
        end
        if (holdoff_req != holdoff_seen) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            i_out_stall  <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_out_stall  <= 1'b1;
        end else begin
            i_out_stall  <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: give up once neither side has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_padded_frame_block_builder NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Hand-picked words: field extremes and every special case of the frame logic.
    task automatic run_directed_cases();
        // Device word straight after reset: nothing expected yet.
        send_word(device_word(64'hFFFF_FFFF_FFFF_FFFF));
        // Header with no devices is itself the final block.
        send_word(header_word(48'h0, 8'd0));
        send_word(device_word(64'h0));
        // Counts above the maximum, at the top of the range and just over.
        send_word(header_word(48'hFFFF_FFFF_FFFF, 8'hFF));
        send_word(header_word(48'(rand64()), 8'(MAX_DEVICES + 1)));
        // Exactly the maximum, then a few payload extremes.
        send_word(header_word(48'hFFFF_FFFF_FFFF, 8'(MAX_DEVICES)));
        send_word(device_word(64'h0));
        send_word(device_word(64'hFFFF_FFFF_FFFF_FFFF));
        send_word(device_word(64'h8040_2010_0804_0201));
        send_word(device_word(64'h7FFE_A55A_0180_FF00));
        // New header mid-frame drops the rest of the old frame.
        send_word(header_word(48'h80_0000_0000_01, 8'd2));
        send_word(device_word(rand64()));
        send_word(device_word(rand64()));
        send_word(device_word(rand64()));
        // Over-count header aborts a frame in flight.
        send_word(header_word(48'(rand64()), 8'd3));
        send_word(device_word(rand64()));
        send_word(header_word(48'(rand64()), 8'd200));
        send_word(device_word(rand64()));
        // Single-device frame.
        send_word(header_word(48'h0605_0403_0201, 8'd1));
        send_word(device_word(64'hFF80_7F01_FE02_FD03));
    endtask

    // Mostly well-formed frames with random content, plus stray device words,
    // over-count headers and frames cut short by the next header.
    task automatic run_random_frames(input int n_words);
        int          stop_at;
        int          kind;
        int          count;
        int          k;
        logic [63:0] r;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            kind = $urandom_range(99);
            r    = rand64();
            if (kind < 8) begin
                send_word(device_word(r));
            end else if (kind < 15) begin
                send_word(header_word(r[47:0], 8'($urandom_range(255, MAX_DEVICES + 1))));
            end else begin
                count = ($urandom_range(7) == 0) ? $urandom_range(MAX_DEVICES)
                                                 : $urandom_range(5);
                send_word(header_word(r[47:0], 8'(count)));
                for (k = 0; k < count; k++) begin
                    if ($urandom_range(99) < 3)
                        break;
                    send_word(device_word(rand64()));
                end
            end
        end
    endtask

    // Hold the output off for a long stretch while a full frame keeps coming,
    // so the block fills and has to stall its input.
    task automatic run_output_holdoff();
        int k;
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        holdoff_req   <= holdoff_req + 1;
        send_word(header_word(48'(rand64()), 8'(MAX_DEVICES)));
        for (k = 0; k < MAX_DEVICES; k++)
            send_word(device_word(rand64()));
        send_word(header_word(48'(rand64()), 8'd0));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender gaps light, receiver stalls heavy.
        send_idle_pct = 33;
        recv_idle_pct <= 73;
        run_directed_cases();
        run_random_frames(250);

        // Swap the pressure round.
        send_idle_pct = 73;
        recv_idle_pct <= 33;
        run_random_frames(250);

        // Full rate both ways.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_random_frames(230);

        run_output_holdoff();

        // Drain: stop offering, wait for every block, then watch for strays.
        i_in_valid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("tb_padded_frame_block_builder OK");
        else
            $display("tb_padded_frame_block_builder NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pfbb_pkg.sv
rtl/pfbb_pad.sv
rtl/pfbb_frame_ctl.sv
rtl/padded_frame_block_builder.sv
bench/tb_padded_frame_block_builder.sv
